@@ src/deq_pkg.sv @@
package deq_pkg;

  // Operation codes carried on the kind field.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Word shown at both ends while the queue holds nothing.
  localparam logic signed [31:0] NEG_ONE = 32'shFFFF_FFFF;

endpackage

@@ src/deq_ram.sv @@
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/double_ended_queue.sv @@
// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid/in_stall  | kind, at_front, push_value
// output  | out       | out_valid/out_stall | status, front_value, rear_value, entry_count
//
// A push, a refused operation or a pop that empties the queue is answered from cached
// end words; a pop that leaves entries behind waits in the read state for the new
// end word from the slot RAM. Reset clears the head index, the occupancy and the
// output valid; the slot RAM is not cleared, as only occupied slots are ever read.
// A new transfer is taken while a result waits only if that result leaves in the
// same cycle; a stalled output holds the input side, as does the read cycle of a pop.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             kind,
  input  logic                             at_front,
  input  logic signed [31:0]               push_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic signed [31:0]               front_value,
  output logic signed [31:0]               rear_value,
  output logic [$clog2(DEPTH+1)-1:0]       entry_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_S = (CW+1)'(DEPTH);
  localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_I  = IW'(DEPTH - 1);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t             state;
  logic [IW-1:0]      head;
  logic [CW-1:0]      occ;
  logic signed [31:0] front_q;
  logic signed [31:0] rear_q;
  logic               pend_front;

  logic               acc;
  logic               is_empty;
  logic               is_full;
  logic [IW-1:0]      head_dec;
  logic [IW-1:0]      head_inc;
  logic [IW-1:0]      tail_wr_addr;
  logic [IW-1:0]      tail_rd_addr;
  logic [IW-1:0]      head_next;
  logic [CW-1:0]      occ_next;
  logic signed [31:0] front_next;
  logic signed [31:0] rear_next;
  logic [1:0]         status_next;
  logic               go_read;
  logic               out_valid_next;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic [31:0]        rd_data;

  // Sum of an index and an offset below twice the depth, folded into the ring.
  function automatic logic [IW-1:0] wrap_idx(input logic [CW:0] s);
    logic [CW:0] r;
    begin
      r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
      return r[IW-1:0];
    end
  endfunction

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign is_empty = (occ == '0);
  assign is_full  = (occ == FULL_C);

  // Ring index arithmetic for both ends.
  always_comb begin
    head_dec     = (head == '0) ? LAST_I : head - IW'(1);
    head_inc     = (head == LAST_I) ? '0 : head + IW'(1);
    tail_wr_addr = wrap_idx((CW+1)'(head) + (CW+1)'(occ));
    tail_rd_addr = wrap_idx((CW+1)'(head) + (CW+1)'(occ) - (CW+1)'(2));
  end

  // Decode the operation into new pointers, cached end words and RAM accesses.
  always_comb begin
    head_next   = head;
    occ_next    = occ;
    front_next  = front_q;
    rear_next   = rear_q;
    status_next = ST_OK;
    go_read     = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = tail_wr_addr;
    rd_en       = 1'b0;
    rd_addr     = tail_rd_addr;
    if (kind == KIND_PUSH) begin
      if (is_full) begin
        status_next = ST_FULL;
      end else begin
        wr_en    = acc;
        occ_next = occ + CW'(1);
        if (at_front) begin
          head_next  = head_dec;
          wr_addr    = head_dec;
          front_next = push_value;
          if (is_empty) begin
            rear_next = push_value;
          end
        end else begin
          rear_next = push_value;
          if (is_empty) begin
            front_next = push_value;
          end
        end
      end
    end else begin
      if (is_empty) begin
        status_next = ST_EMPTY;
      end else begin
        occ_next = occ - CW'(1);
        if (occ != CW'(1)) begin
          go_read = 1'b1;
          rd_en   = acc;
          if (at_front) begin
            head_next = head_inc;
            rd_addr   = head_inc;
          end
        end
      end
    end
  end

  // The result is held while stalled and raised by an operation that needs no read or a finished read.
  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (state == S_READ) begin
      out_valid_next = 1'b1;
    end else if (acc && !go_read) begin
      out_valid_next = 1'b1;
    end
  end

  deq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer, queue pointers, cached end words and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      head      <= '0;
      occ       <= '0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            head       <= head_next;
            occ        <= occ_next;
            front_q    <= front_next;
            rear_q     <= rear_next;
            pend_front <= at_front;
            if (go_read) begin
              state <= S_READ;
            end else begin
              status      <= status_next;
              entry_count <= occ_next;
              front_value <= (occ_next == '0) ? NEG_ONE : front_next;
              rear_value  <= (occ_next == '0) ? NEG_ONE : rear_next;
            end
          end
        end
        S_READ: begin
          state       <= S_IDLE;
          status      <= ST_OK;
          entry_count <= occ;
          if (pend_front) begin
            front_q     <= rd_data;
            front_value <= rd_data;
            rear_value  <= rear_q;
          end else begin
            rear_q      <= rd_data;
            front_value <= front_q;
            rear_value  <= rd_data;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The occupancy never passes the ring size.
  assert property (@(posedge clk) disable iff (rst) occ <= FULL_C)
    else $error("occupancy above depth");

  // An empty result shows the empty marker at both ends.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_count == '0) |-> (front_value == NEG_ONE && rear_value == NEG_ONE))
    else $error("empty result without marker values");

  // A refused push is reported only with a full queue.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (entry_count == FULL_C))
    else $error("full status with free slots");

  // A taken transfer that needs a read enters the read wait straight after, with no result valid.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && acc && go_read) |=> (state == S_READ && !out_valid))
    else $error("pop read sequencing broken");

endmodule

@@ tb/double_ended_queue_tb.sv @@
// Mirror of the double-ended queue: it keeps its own ring of words and
// works out the result that each accepted operation must produce.
class deque_mirror;
  localparam int RING_DEPTH = 16;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic [4:0]         entry_count;
  } view_t;

  logic signed [31:0] ring [RING_DEPTH];
  int                 head;
  int                 fill;
  view_t              expected_views [$];
  int                 failures;
  int                 views_seen;

  function new();
    head       = 0;
    fill       = 0;
    failures   = 0;
    views_seen = 0;
  endfunction

  // Apply one accepted operation and queue the view it must produce.
  function void note_operation(logic op, logic front_end, logic signed [31:0] word);
    view_t v;
    v.status = deq_pkg::ST_OK;
    if (op == deq_pkg::KIND_PUSH) begin
      if (fill >= RING_DEPTH) begin
        v.status = deq_pkg::ST_FULL;
      end else if (front_end) begin
        head       = (head + RING_DEPTH - 1) % RING_DEPTH;
        ring[head] = word;
        fill++;
      end else begin
        ring[(head + fill) % RING_DEPTH] = word;
        fill++;
      end
    end else if (fill == 0) begin
      v.status = deq_pkg::ST_EMPTY;
    end else begin
      // The head only moves when a front pop leaves entries behind.
      if (front_end && fill > 1) head = (head + 1) % RING_DEPTH;
      fill--;
    end

    if (fill != 0) begin
      v.front_value = ring[head];
      v.rear_value  = ring[(head + fill - 1) % RING_DEPTH];
    end else begin
      v.front_value = deq_pkg::NEG_ONE;
      v.rear_value  = deq_pkg::NEG_ONE;
    end
    v.entry_count = 5'(fill);
    expected_views.push_back(v);
  endfunction

  // Compare one accepted result with the oldest expected view.
  function void check_view(logic [1:0] st, logic signed [31:0] fv,
                           logic signed [31:0] rv, logic [4:0] cnt);
    view_t e;
    views_seen++;
    if (expected_views.size() == 0) begin
      $error("result with no operation waiting: status %0d entry_count %0d", st, cnt);
      failures++;
      return;
    end
    e = expected_views.pop_front();
    if (st !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, st);
      failures++;
    end
    if (fv !== e.front_value) begin
      $error("front_value: expected %0d, actual %0d", e.front_value, fv);
      failures++;
    end
    if (rv !== e.rear_value) begin
      $error("rear_value: expected %0d, actual %0d", e.rear_value, rv);
      failures++;
    end
    if (cnt !== e.entry_count) begin
      $error("entry_count: expected %0d, actual %0d", e.entry_count, cnt);
      failures++;
    end
  endfunction
endclass

module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int ITEM_TARGET  = 550;
  localparam int CALM_FIRST   = 150;
  localparam int CALM_LAST    = 250;
  localparam int HOLD_AT      = 350;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_PERCENT = 26;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               kind;
  logic               at_front;
  logic signed [31:0] push_value;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic signed [31:0] front_value;
  logic signed [31:0] rear_value;
  logic [4:0]         entry_count;

  deque_mirror board = new();
  int          sent = 0;

  double_ended_queue #(.DEPTH(QUEUE_DEPTH)) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .at_front    (at_front),
    .push_value  (push_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .front_value (front_value),
    .rear_value  (rear_value),
    .entry_count (entry_count)
  );

  // Clock with a period of twelve units.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one operation, with random gaps outside the calm stretch, and hold
  // it until the transfer takes place.
  task automatic send_op(input logic op, input logic front_end,
                         input logic signed [31:0] word);
    @(negedge clk);
    while (!(sent >= CALM_FIRST && sent < CALM_LAST) &&
           $urandom_range(99) < IDLE_PERCENT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    kind       = op;
    at_front   = front_end;
    push_value = word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_operation(op, front_end, word);
    sent++;
  endtask

  // Mostly random words, now and then one of the extremes.
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return NEG_ONE;
      3:       return 32'sh0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: a directed opening, then bursts biased towards pushes or pops.
  initial begin
    int   burst_len;
    int   push_pct;
    int   drain_cycles;
    logic op;

    rst        = 1'b1;
    in_valid   = 1'b0;
    kind       = KIND_PUSH;
    at_front   = 1'b0;
    push_value = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Pops on the empty queue at both ends.
    send_op(KIND_POP, 1'b1, $urandom);
    send_op(KIND_POP, 1'b0, $urandom);
    // A single entry removed from either end.
    send_op(KIND_PUSH, 1'b0, 32'sh7FFF_FFFF);
    send_op(KIND_POP, 1'b1, $urandom);
    send_op(KIND_PUSH, 1'b1, 32'sh8000_0000);
    send_op(KIND_POP, 1'b0, $urandom);
    // Fill the store from both ends, then push on the full store.
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      case (i)
        0:       send_op(KIND_PUSH, 1'b1, NEG_ONE);
        1:       send_op(KIND_PUSH, 1'b0, 32'sh0000_0000);
        2:       send_op(KIND_PUSH, 1'b1, 32'sh7FFF_FFFF);
        3:       send_op(KIND_PUSH, 1'b0, 32'sh8000_0000);
        default: send_op(KIND_PUSH, i[0], $urandom);
      endcase
    end
    send_op(KIND_PUSH, 1'b1, $urandom);
    send_op(KIND_PUSH, 1'b0, $urandom);

    // Random bursts swing the queue between empty and full.
    while (sent < ITEM_TARGET) begin
      burst_len = $urandom_range(8, 40);
      case ($urandom_range(2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < burst_len; i++) begin
        op = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
        send_op(op, 1'($urandom_range(1)), pick_word());
      end
    end
    @(negedge clk);
    in_valid = 1'b0;

    // Wait for the outstanding results, then keep watching for strays.
    drain_cycles = 0;
    while (board.expected_views.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (board.expected_views.size() != 0) begin
      $error("%0d expected results never arrived", board.expected_views.size());
      board.failures++;
    end
    repeat (10) @(posedge clk);

    if (board.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: random stalls, a calm stretch and one long hold-off that
  // backs the block up into its input.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!hold_done && board.views_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (board.views_seen >= CALM_FIRST && board.views_seen < CALM_LAST) begin
        out_stall = 1'b0;
      end else begin
        out_stall = ($urandom_range(99) < IDLE_PERCENT);
      end
      @(posedge clk);
      if (out_valid && !out_stall) begin
        board.check_view(status, front_value, rear_value, entry_count);
      end
    end
  end

  // Watchdog in case the block hangs.
  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
